### rtl/spq_pkg.sv
//------------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation and status codes, and the control word of the cell row.
//------------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CAP_W      = 5;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic                         insert;
		logic                         remove;
		logic signed [DATA_WIDTH-1:0] key;
	} cell_ctl_t;

endpackage

### rtl/spq_if.sv
//------------------------------------------------------------------------------
// Sorted priority queue channels
// Request, response and configuration channels with valid and ready.
//------------------------------------------------------------------------------
interface spq_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 op;
	logic signed [spq_pkg::DATA_WIDTH-1:0] value_in;

	modport source (output valid, output op, output value_in, input ready);
	modport sink   (input valid, input op, input value_in, output ready);
endinterface

interface spq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [spq_pkg::DATA_WIDTH-1:0] value_out;
	logic [1:0]                           status;

	modport source (output valid, output value_out, output status, input ready);
	modport sink   (input valid, input value_out, input status, output ready);
endinterface

interface spq_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [spq_pkg::CAP_W-1:0]   capacity_in_use;

	modport source (output valid, output capacity_in_use, input ready);
	modport sink   (input valid, input capacity_in_use, output ready);
endinterface

### rtl/spq_cell.sv
//------------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the sorted row and shifts it toward its neighbors.
//------------------------------------------------------------------------------
module spq_cell (
	input  logic                                  clk,
	input  spq_pkg::cell_ctl_t                    ctl,
	input  logic                                  occupied,
	input  logic                                  tail,
	input  logic                                  left_gt,
	input  logic signed [spq_pkg::DATA_WIDTH-1:0] left_data,
	input  logic signed [spq_pkg::DATA_WIDTH-1:0] right_data,
	output logic signed [spq_pkg::DATA_WIDTH-1:0] data,
	output logic                                  gt
);

	logic signed [spq_pkg::DATA_WIDTH-1:0] data_q;

	assign data = data_q;
	assign gt   = occupied && (data_q > ctl.key);

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (left_gt) begin
				data_q <= left_data;
			end else if (gt || tail) begin
				data_q <= ctl.key;
			end
		end else if (ctl.remove) begin
			data_q <= right_data;
		end
	end

endmodule

### rtl/sorted_priority_queue.sv
//------------------------------------------------------------------------------
// Sorted priority queue
// Minimum-first queue kept as a row of cells in ascending order.
//------------------------------------------------------------------------------
// A word on req carries an operation: insert value_in, or remove the smallest
// entry. Each accepted word gives one word on rsp with the removed value and a
// status: ok, overflow when an insert finds the queue at its limit, underflow
// when a remove finds it empty. Equal values leave in arrival order.
// Every cell compares its entry with the inserted value in the same cycle and
// shifts by one place, and the response is registered: it appears in the
// cycle after acceptance, and one word per cycle is sustained while rsp is
// taken. When rsp stalls, the response register holds and req is not ready
// until it drains.
// The cfg channel sets the limit on stored entries; limits above the depth
// act as the depth, and zero makes every insert overflow. It is always ready.
// Reset empties the queue, clears the response valid flag and sets the limit
// to the depth. Entries need no clearing.
//------------------------------------------------------------------------------
module sorted_priority_queue (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp,
	spq_cfg_if.sink   cfg
);

	localparam int DEPTH = spq_pkg::DEPTH;
	localparam int DW    = spq_pkg::DATA_WIDTH;
	localparam int CNT_W = spq_pkg::CNT_W;
	localparam int CMP_W = spq_pkg::CMP_W;

	logic [spq_pkg::CAP_W-1:0] cap_q;
	logic [CNT_W-1:0]          count_q;
	logic                      rsp_valid_q;
	logic signed [DW-1:0]      value_out_q;
	spq_pkg::status_t          status_q;

	logic                      req_fire;
	logic                      full;
	logic                      empty;
	logic                      ins_ok;
	logic                      rem_ok;
	spq_pkg::cell_ctl_t        ctl;
	logic signed [DW-1:0]      cell_data [DEPTH];
	logic                      cell_gt   [DEPTH];

	assign req_fire = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	assign full  = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign ins_ok = req_fire && (req.op == spq_pkg::OP_INSERT) && !full;
	assign rem_ok = req_fire && (req.op == spq_pkg::OP_REMOVE) && !empty;

	assign ctl.insert = ins_ok;
	assign ctl.remove = rem_ok;
	assign ctl.key    = req.value_in;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                 left_gt;
			logic signed [DW-1:0] left_data;
			logic signed [DW-1:0] right_data;

			if (i == 0) begin : g_first
				assign left_gt   = 1'b0;
				assign left_data = '0;
			end else begin : g_mid
				assign left_gt   = cell_gt[i-1];
				assign left_data = cell_data[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign right_data = '0;
			end else begin : g_body
				assign right_data = cell_data[i+1];
			end

			spq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occupied   (count_q > CNT_W'(i)),
				.tail       (count_q == CNT_W'(i)),
				.left_gt    (left_gt),
				.left_data  (left_data),
				.right_data (right_data),
				.data       (cell_data[i]),
				.gt         (cell_gt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= spq_pkg::CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.capacity_in_use;
			end
			if (ins_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rem_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			value_out_q <= rem_ok ? cell_data[0] : '0;
			if (req.op == spq_pkg::OP_INSERT) begin
				status_q <= full ? spq_pkg::STATUS_OVERFLOW : spq_pkg::STATUS_OK;
			end else begin
				status_q <= empty ? spq_pkg::STATUS_UNDERFLOW : spq_pkg::STATUS_OK;
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.value_out = value_out_q;
	assign rsp.status    = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.op == spq_pkg::OP_REMOVE) && empty
		|=> rsp_valid_q && (status_q == spq_pkg::STATUS_UNDERFLOW) && (count_q == '0))
		else $error("remove from empty queue not reported");

	a_overflow_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.op == spq_pkg::OP_INSERT) && full
		|=> $stable(count_q) && (status_q == spq_pkg::STATUS_OVERFLOW))
		else $error("overflowing insert changed the queue");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > CNT_W'(1)) |-> (cell_data[0] <= cell_data[1]))
		else $error("front entries out of order");

endmodule

### tb/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Sorted priority queue testbench
// Sends insert and remove words to the queue through a short table of directed
// words and then six random phases, each with its own capacity limit; the idle
// pattern changes every two phases. Every response word is checked against a
// sorted-list predictor kept in this file, or a fixed value on some rows.
//------------------------------------------------------------------------------
module tb_sorted_priority_queue;

	localparam int ITEMS_PER_PHASE = 64;
	localparam int PHASES          = 6;
	localparam int RSP_HOLD_CYCLES = 48;
	localparam int WATCHDOG_LIMIT  = 2000;

	typedef struct packed {
		logic signed [spq_pkg::DATA_WIDTH-1:0] value;
		spq_pkg::status_t                      status;
	} rsp_word_t;

	typedef enum logic {
		ROW_OP,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t                             kind;
		spq_pkg::op_t                          op;
		logic signed [spq_pkg::DATA_WIDTH-1:0] data;
		logic                                  fixed;
		logic signed [spq_pkg::DATA_WIDTH-1:0] fix_value;
		spq_pkg::status_t                      fix_status;
	} plan_row_t;

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();
	spq_cfg_if cfg_ch ();

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic signed [spq_pkg::DATA_WIDTH-1:0] held_values[$];
	int unsigned                           held_limit = spq_pkg::CAP_RESET;
	int unsigned                           deepest_fill = 0;
	rsp_word_t                             pending_rsp[$];
	plan_row_t                             plan_table[$];

	int  send_idle_pct = 19;
	int  recv_idle_pct = 70;
	bit  hold_rsp = 1'b0;
	bit  offering = 1'b0;
	int  mismatch_count = 0;
	int  words_in = 0;
	int  words_out = 0;
	int  overflow_seen = 0;
	int  underflow_seen = 0;
	int  quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic rsp_word_t pq_response(input spq_pkg::op_t op,
			input logic signed [spq_pkg::DATA_WIDTH-1:0] data);
		rsp_word_t   r;
		int unsigned lim;
		int          pos;
		r.value  = '0;
		r.status = spq_pkg::STATUS_OK;
		lim = (held_limit > spq_pkg::DEPTH) ? spq_pkg::DEPTH : held_limit;
		if (op == spq_pkg::OP_INSERT) begin
			if (held_values.size() >= lim) begin
				r.status = spq_pkg::STATUS_OVERFLOW;
			end else begin
				held_values.push_back(data);
				pos = held_values.size() - 1;
				while (pos > 0 && held_values[pos-1] > data) begin
					held_values[pos] = held_values[pos-1];
					pos--;
				end
				held_values[pos] = data;
				if (held_values.size() > deepest_fill)
					deepest_fill = held_values.size();
			end
		end else if (held_values.size() == 0) begin
			r.status = spq_pkg::STATUS_UNDERFLOW;
		end else begin
			r.value = held_values.pop_front();
		end
		return r;
	endfunction

	function automatic logic signed [spq_pkg::DATA_WIDTH-1:0] pick_value();
		logic signed [spq_pkg::DATA_WIDTH-1:0] v;
		case ($urandom_range(3))
			0: v = $signed(spq_pkg::DATA_WIDTH'($urandom_range(8))) - 4;
			1: begin
				case ($urandom_range(3))
					0: v = {1'b1, {(spq_pkg::DATA_WIDTH-1){1'b0}}};
					1: v = {1'b0, {(spq_pkg::DATA_WIDTH-1){1'b1}}};
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_word(input spq_pkg::op_t op,
			input logic signed [spq_pkg::DATA_WIDTH-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			if (offering) begin
				req_ch.valid <= 1'b0;
				offering = 1'b0;
			end
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.value_in <= data;
		offering = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		words_in++;
	endtask

	task automatic drain_responses();
		if (offering) begin
			req_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [spq_pkg::CAP_W-1:0] cap);
		drain_responses();
		cfg_ch.valid           <= 1'b1;
		cfg_ch.capacity_in_use <= cap;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		held_limit = cap;
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response word with no request outstanding: value_out %0d, status %0d",
					rsp_ch.value_out, rsp_ch.status);
				mismatch_count++;
			end else begin
				want = pending_rsp.pop_front();
				words_out++;
				if (want.status == spq_pkg::STATUS_OVERFLOW)
					overflow_seen++;
				if (want.status == spq_pkg::STATUS_UNDERFLOW)
					underflow_seen++;
				if (rsp_ch.value_out !== want.value) begin
					$error("value_out mismatch: expected %0d, actual %0d",
						want.value, rsp_ch.value_out);
					mismatch_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.status, rsp_ch.status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [spq_pkg::CAP_W-1:0]             phase_cap [PHASES];
		rsp_word_t                             predicted;
		spq_pkg::op_t                          op;
		logic signed [spq_pkg::DATA_WIDTH-1:0] v;
		int                                    ins_pct;

		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.op              <= spq_pkg::OP_INSERT;
		req_ch.value_in        <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.capacity_in_use <= '0;

		plan_table = '{
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b1, 32'h0, spq_pkg::STATUS_UNDERFLOW},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h8000_0000, 1'b1, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h0000_0000, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000,
				spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b1, 32'h7FFF_FFFF, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b1, 32'h0, spq_pkg::STATUS_UNDERFLOW},
			'{ROW_CFG, spq_pkg::OP_INSERT, 32'd0, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h0000_0001, 1'b1, 32'h0, spq_pkg::STATUS_OVERFLOW},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h0, spq_pkg::STATUS_OVERFLOW},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b1, 32'h0, spq_pkg::STATUS_UNDERFLOW},
			'{ROW_CFG, spq_pkg::OP_INSERT, 32'd1, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h5555_5555, 1'b1, 32'h0, spq_pkg::STATUS_OVERFLOW},
			'{ROW_CFG, spq_pkg::OP_INSERT, 32'd0, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h0000_0000, 1'b1, 32'h0, spq_pkg::STATUS_OVERFLOW},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_CFG, spq_pkg::OP_INSERT, 32'd31, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'h0000_0003, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_INSERT, 32'hFFFF_FFFD, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, spq_pkg::STATUS_OK},
			'{ROW_OP,  spq_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, spq_pkg::STATUS_OK}
		};

		phase_cap[0] = 5'd31;
		phase_cap[1] = 5'd2;
		phase_cap[2] = 5'd16;
		phase_cap[3] = spq_pkg::CAP_W'($urandom_range(15, 1));
		phase_cap[4] = spq_pkg::CAP_W'($urandom_range(30, 17));
		phase_cap[5] = 5'd1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan_table[i]) begin
			if (plan_table[i].kind == ROW_CFG) begin
				write_capacity(plan_table[i].data[spq_pkg::CAP_W-1:0]);
			end else begin
				send_word(plan_table[i].op, plan_table[i].data);
				predicted = pq_response(plan_table[i].op, plan_table[i].data);
				if (plan_table[i].fixed)
					predicted = '{plan_table[i].fix_value, plan_table[i].fix_status};
				pending_rsp.push_back(predicted);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) begin
				send_idle_pct = 70;
				recv_idle_pct = 19;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_capacity(phase_cap[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					drain_responses();
				if (p == 1 && n == 8)
					hold_rsp = 1'b1;
				ins_pct = ((n / 16) % 2 == 0) ? 85 : 30;
				op = ($urandom_range(99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
				v = pick_value();
				send_word(op, v);
				pending_rsp.push_back(pq_response(op, v));
			end
		end

		drain_responses();
		repeat (4) @(posedge clk);

		$display("Sent %0d request words and checked %0d response words (%0d overflow, %0d underflow).",
			words_in, words_out, overflow_seen, underflow_seen);
		$display("Capacity limits from 0 to 31 were used; the queue held up to %0d entries.",
			deepest_fill);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
